FILE: sv/sapq_pkg.sv
// Shared types and constants for the sorted-array priority queue.
// No dependencies; every other file imports this package.
package sapq_pkg;

  localparam int CAPACITY       = 16;
  localparam int DATA_WIDTH     = 16;
  localparam int PRIORITY_WIDTH = 8;
  localparam int SLOT_W         = 4;
  localparam int CNT_W          = 5;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_REMOVED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    op_e                       operation;
    logic [DATA_WIDTH-1:0]     item_data;
    logic [PRIORITY_WIDTH-1:0] item_priority;
  } in_word_t;

  typedef struct packed {
    status_e                   status;
    logic [DATA_WIDTH-1:0]     out_data;
    logic [PRIORITY_WIDTH-1:0] out_priority;
    logic [SLOT_W-1:0]         insert_slot;
    logic [CNT_W-1:0]          occupancy;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

FILE: sv/sapq_datapath.sv
// Datapath of the priority queue: input register, sorted entry cells with
// parallel compare and shift, entry count and result register. Uses sapq_pkg.
module sapq_datapath import sapq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_cmd_t   cmd_i,
  input  in_word_t  in_word_i,
  output out_word_t out_word_o
);

  in_word_t                  in_q;
  out_word_t                 out_q, out_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [DATA_WIDTH-1:0]     data_q [CAPACITY];
  logic [DATA_WIDTH-1:0]     data_d [CAPACITY];
  logic [PRIORITY_WIDTH-1:0] pri_q  [CAPACITY];
  logic [PRIORITY_WIDTH-1:0] pri_d  [CAPACITY];
  logic [CAPACITY-1:0]       le;
  logic [CAPACITY-1:0]       boundary;
  logic [SLOT_W-1:0]         slot;
  logic                      full, empty;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  // Held entries with priority lower or equal to the new one form a prefix,
  // so the insert slot is the first cell outside that prefix.
  always_comb begin
    slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      le[i] = (CNT_W'(i) < count_q) && (pri_q[i] <= in_q.item_priority);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      boundary[i] = !le[i] && ((i == 0) || le[(i == 0) ? 0 : i - 1]);
      if (boundary[i]) begin
        slot = slot | SLOT_W'(i);
      end
    end
  end

  always_comb begin
    out_d   = out_q;
    count_d = count_q;
    for (int i = 0; i < CAPACITY; i++) begin
      data_d[i] = data_q[i];
      pri_d[i]  = pri_q[i];
    end
    if (cmd_i.execute) begin
      out_d = '0;
      if (in_q.operation == OP_ADD) begin
        if (full) begin
          out_d.status    = ST_FULL;
          out_d.occupancy = count_q;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (boundary[i]) begin
              data_d[i] = in_q.item_data;
              pri_d[i]  = in_q.item_priority;
            end else if (!le[i] && i > 0) begin
              data_d[i] = data_q[(i == 0) ? 0 : i - 1];
              pri_d[i]  = pri_q[(i == 0) ? 0 : i - 1];
            end
          end
          count_d           = count_q + CNT_W'(1);
          out_d.status      = ST_ADDED;
          out_d.insert_slot = slot;
          out_d.occupancy   = count_d;
        end
      end else begin
        if (empty) begin
          out_d.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            data_d[i] = data_q[i+1];
            pri_d[i]  = pri_q[i+1];
          end
          count_d            = count_q - CNT_W'(1);
          out_d.status       = ST_REMOVED;
          out_d.out_data     = data_q[0];
          out_d.out_priority = pri_q[0];
          out_d.occupancy    = count_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_word_i;
    end
    out_q <= out_d;
    for (int i = 0; i < CAPACITY; i++) begin
      data_q[i] <= data_d[i];
      pri_q[i]  <= pri_d[i];
    end
  end

  assign out_word_o = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && in_q.operation == OP_ADD && !full
      |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("add did not grow the queue");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && in_q.operation == OP_REMOVE && !empty
      |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("remove did not shrink the queue");

  a_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.execute |=> $stable(count_q))
    else $error("entry count changed without an operation");

endmodule

FILE: sv/sapq_ctrl.sv
// Controller of the priority queue: accepts one word, runs it through the
// datapath and holds the result valid flag. Uses sapq_pkg.
module sapq_ctrl import sapq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && out_stall_i;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        // The result register must be free before the operation commits.
        if (out_free) begin
          cmd_o.execute = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_exec_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |-> out_free)
    else $error("result overwritten before it was taken");

  a_capture_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == S_EXEC && !cmd_o.capture)
    else $error("capture not followed by execution state");

  a_exec_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> out_valid_o)
    else $error("execution produced no result word");

endmodule

FILE: sv/sorted_array_priority_queue_core.sv
// Sorted-array priority queue, 16 entries kept in ascending priority order.
// Each word is handled in two steps: it is first registered, then the parallel
// compare-and-shift runs across all entry cells; the input stalls during the
// second step. A finished result waits in its own register, so the next word is
// taken while it is pending, but the shift step waits until that register is
// free. Uses sapq_pkg, sapq_ctrl and sapq_datapath.
module sorted_array_priority_queue_core import sapq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  dp_cmd_t cmd;

  sapq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  sapq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule
